>>> rtl/plp_pkg.sv
// ----------------------------------------------------------------------------
// plp_pkg: shared definitions for the POV line player
// Command codes, field widths, defaults and the controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package plp_pkg;

  localparam int LINE_WIDTH_DEF  = 48;
  localparam int STORE_DEPTH_DEF = 4096;

  localparam int CMD_W       = 2;
  localparam int IN_LINE_W   = 48;
  localparam int INTERVAL_W  = 24;
  localparam int BIT_INDEX_W = 6;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 24'd10000;

  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic take;   // input request accepted this cycle
    logic load;   // load shift register from store read data
    logic shift;  // output bit taken, advance shift register
  } plp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic expire;    // offered request is a tick that ends the interval
    logic last_bit;  // shift register sits on the last bit of the line
  } plp_stat_t;

endpackage

`default_nettype wire

>>> rtl/plp_ram.sv
// ----------------------------------------------------------------------------
// plp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module plp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/plp_ctrl.sv
// ----------------------------------------------------------------------------
// plp_ctrl: sequencing state machine of the POV line player
// Accepts requests while idle, then loads and shifts out one line per expiry.
// ----------------------------------------------------------------------------
`default_nettype none

module plp_ctrl
  import plp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire plp_stat_t stat,
  output plp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_LOAD  = 3'b010,
    ST_SHIFT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.expire) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.shift = 1'b1;
          if (stat.last_bit) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a line is being shifted out");
  a_load_then_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |=> out_valid)
    else $error("load not followed by output");
  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift && stat.last_bit) |=> !out_valid && !in_stall)
    else $error("line did not end after its last bit");
  a_expire_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && stat.expire) |=> (state_r == ST_LOAD))
    else $error("expiring tick did not start a line");
`endif

endmodule

`default_nettype wire

>>> rtl/plp_dp.sv
// ----------------------------------------------------------------------------
// plp_dp: datapath of the POV line player
// Line store, count and play position, tick timer, interval and shift register.
// ----------------------------------------------------------------------------
`default_nettype none

module plp_dp
  import plp_pkg::*;
#(
  parameter int LINE_WIDTH  = LINE_WIDTH_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire plp_cmd_t               cmd,
  output plp_stat_t                   stat,
  input  wire logic [CMD_W-1:0]       in_command,
  input  wire logic [IN_LINE_W-1:0]   in_line_bits,
  input  wire logic                   cfg_we,
  input  wire logic [INTERVAL_W-1:0]  cfg_data,
  output logic                        out_data_bit,
  output logic [BIT_INDEX_W-1:0]      out_bit_index,
  output logic                        out_latch
);

  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W  = $clog2(LINE_WIDTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(LINE_WIDTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(STORE_DEPTH);

  logic [INTERVAL_W-1:0] interval_r;
  logic [INTERVAL_W-1:0] tick_r;
  logic [CNT_W-1:0]      count_r;
  logic [ADDR_W-1:0]     pos_r;
  logic                  empty_r;
  logic [LINE_WIDTH-1:0] shift_r;
  logic [IDX_W-1:0]      idx_r;

  logic [INTERVAL_W-1:0] tick_inc;
  logic [INTERVAL_W-1:0] limit;
  logic                  expire;
  logic [ADDR_W-1:0]     cur_pos;
  logic [CNT_W-1:0]      cur_inc;
  logic                  not_full;
  logic                  ram_we;
  logic [LINE_WIDTH-1:0] wr_line;
  logic [LINE_WIDTH-1:0] rd_line;
  logic [63:0]           in_line_ext;

  always_comb begin
    tick_inc = tick_r + INTERVAL_W'(1);
    limit    = (interval_r == '0) ? INTERVAL_W'(1) : interval_r;
    expire   = !((tick_inc < limit) && (tick_inc != '0));
    // wrap to line 0 when a remove left the position past the count
    cur_pos  = (CNT_W'(pos_r) >= count_r) ? '0 : pos_r;
    cur_inc  = CNT_W'(cur_pos) + CNT_W'(1);
    not_full = count_r < FULL_CNT;
    ram_we   = cmd.take && (in_command == CMD_APPEND) && not_full;
    in_line_ext = 64'(in_line_bits);
    wr_line  = in_line_ext[LINE_WIDTH-1:0];
    stat.expire   = (in_command == CMD_TICK) && expire;
    stat.last_bit = (idx_r == LAST_IDX);
  end

  plp_ram #(
    .WIDTH (LINE_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (count_r[ADDR_W-1:0]),
    .wdata   (wr_line),
    .raddr   (cur_pos),
    .rdata_r (rd_line)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RESET;
      tick_r     <= '0;
      count_r    <= '0;
      pos_r      <= '0;
    end else begin
      if (cfg_we) begin
        interval_r <= cfg_data;
      end
      if (cmd.take) begin
        case (in_command)
          CMD_APPEND: begin
            if (not_full) begin
              count_r <= count_r + CNT_W'(1);
            end
          end
          CMD_CLEAR: begin
            count_r <= '0;
            pos_r   <= '0;
          end
          CMD_REMOVE: begin
            if (count_r != '0) begin
              count_r <= count_r - CNT_W'(1);
            end
          end
          default: begin
            if (expire) begin
              tick_r <= '0;
              if (count_r != '0) begin
                pos_r <= (cur_inc >= count_r) ? '0 : cur_inc[ADDR_W-1:0];
              end
            end else begin
              tick_r <= tick_inc;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      empty_r <= (count_r == '0);
    end
    if (cmd.load) begin
      shift_r <= empty_r ? '0 : rd_line;
      idx_r   <= '0;
    end else if (cmd.shift) begin
      shift_r <= shift_r >> 1;
      idx_r   <= idx_r + IDX_W'(1);
    end
  end

  assign out_data_bit  = shift_r[0];
  assign out_bit_index = BIT_INDEX_W'(idx_r);
  assign out_latch     = stat.last_bit;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("line count above store depth");
  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (count_r < FULL_CNT))
    else $error("store written while full");
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && stat.expire && (count_r != '0)) |=> (CNT_W'(pos_r) < count_r))
    else $error("play position left outside the stored lines");
`endif

endmodule

`default_nettype wire

>>> rtl/pov_line_player.sv
// ----------------------------------------------------------------------------
// pov_line_player: serial line player for a rotating LED display
// Stores LED lines and shifts one out, bit by bit, each time the interval ends.
// ----------------------------------------------------------------------------
// Requests on the input channel are ticks, appends, clears and removes. An
// append, clear, remove or non-expiring tick gives no output. A tick that
// ends the interval is handled in steps: the request is taken and the store
// read, the shift register is loaded from the registered RAM read, then the
// line goes out one serial bit at a time, held while the output stalls.
// While a line is shifting, the input is stalled. The store comes up empty
// (count zero); its RAM needs no clearing pass, since only entries below the
// count are ever read. The user must write the interval register only while
// the block is idle, through the cfg_ port, which is always ready; the block
// itself does not enforce this. An interval of zero acts as one.
// ----------------------------------------------------------------------------
`default_nettype none

module pov_line_player
  import plp_pkg::*;
#(
  parameter int LINE_WIDTH  = LINE_WIDTH_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // request channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [CMD_W-1:0]       in_command,
  input  wire logic [IN_LINE_W-1:0]   in_line_bits,
  // serial bit channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_data_bit,
  output logic [BIT_INDEX_W-1:0]      out_bit_index,
  output logic                        out_latch,
  // interval register write
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [INTERVAL_W-1:0]  cfg_data
);

  plp_cmd_t  cmd;
  plp_stat_t stat;

  // the interval register takes a write in any cycle
  assign cfg_ready = 1'b1;

  plp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  plp_dp #(
    .LINE_WIDTH  (LINE_WIDTH),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_command    (in_command),
    .in_line_bits  (in_line_bits),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .out_data_bit  (out_data_bit),
    .out_bit_index (out_bit_index),
    .out_latch     (out_latch)
  );

endmodule

`default_nettype wire

>>> dv/pov_line_player_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pov_line_player_tb: self-checking bench for the POV line player
// Drives tick, append, clear and remove requests and rewrites the interval
// register between phases. Every serial bit on the output channel is checked
// against a line store and tick counter kept inside the bench.
// ----------------------------------------------------------------------------

module pov_line_player_tb;
  import plp_pkg::*;

  localparam int LW          = LINE_WIDTH_DEF;
  localparam int DEPTH       = STORE_DEPTH_DEF;
  localparam int SETTLE_CYC  = LW + 8;     // worst line drain after the last bit
  localparam int HOLD_CYCLES = 400;        // long receiver hold-off
  localparam int QUIET_LIMIT = 4000;       // cycles with no handshake at all
  localparam int RAND_ITEMS  = 18;         // random requests per idling phase

  // how a directed row gets its expected bits
  typedef enum logic [1:0] {
    EXP_MODEL,  // ask the bench's own player
    EXP_QUIET,  // row must give no output
    EXP_LINE    // row gives the typed line
  } exp_kind_t;

  typedef struct packed {
    logic                  set_cfg;
    logic [INTERVAL_W-1:0] cfg_val;
    logic [CMD_W-1:0]      cmd;
    logic [IN_LINE_W-1:0]  bits;
    logic [15:0]           reps;
    exp_kind_t             kind;
    logic [LW-1:0]         line;
  } plan_row_t;

  typedef struct packed {
    logic                   data_bit;
    logic [BIT_INDEX_W-1:0] bit_index;
    logic                   latch;
  } serial_bit_t;

  // --------------------------------------------------------------------------
  // DUT signals: every input starts at a known value
  // --------------------------------------------------------------------------
  logic                   clk           = 1'b0;
  logic                   rst_n         = 1'b0;
  logic                   in_valid      = 1'b0;
  logic                   in_stall;
  logic [CMD_W-1:0]       in_command    = CMD_TICK;
  logic [IN_LINE_W-1:0]   in_line_bits  = '0;
  logic                   out_valid;
  logic                   out_stall     = 1'b0;
  logic                   out_data_bit;
  logic [BIT_INDEX_W-1:0] out_bit_index;
  logic                   out_latch;
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [INTERVAL_W-1:0]  cfg_data      = '0;

  pov_line_player u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_line_bits  (in_line_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data_bit  (out_data_bit),
    .out_bit_index (out_bit_index),
    .out_latch     (out_latch),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench copy of the player state
  // --------------------------------------------------------------------------
  logic [LW-1:0]         shadow_store [DEPTH];
  logic [12:0]           shadow_count    = '0;
  logic [11:0]           shadow_pos      = '0;
  logic [INTERVAL_W-1:0] shadow_ticks    = '0;
  logic [INTERVAL_W-1:0] shadow_interval = INTERVAL_RESET;

  serial_bit_t pending_bits [$];   // serial bits still owed by the DUT
  plan_row_t   plan [$];

  int err_count    = 0;
  int req_taken    = 0;
  int bits_checked = 0;
  int cfg_writes   = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_req     = 0;   // bumped by the sender to ask for a hold-off
  int hold_seen    = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Advance the shadow player by one request. Return 1 when a line is shown,
  // with the line in shown.
  function automatic bit step_player(input logic [CMD_W-1:0] cmd,
                                     input logic [IN_LINE_W-1:0] bits,
                                     output logic [LW-1:0] shown);
    logic [INTERVAL_W-1:0] lim;
    logic [INTERVAL_W-1:0] nxt;
    shown = '0;
    step_player = 1'b0;
    case (cmd)
      CMD_APPEND: begin
        // drop the append once the store is full
        if (shadow_count < DEPTH) begin
          shadow_store[shadow_count[11:0]] = bits[LW-1:0];
          shadow_count = shadow_count + 1'b1;
        end
      end
      CMD_CLEAR: begin
        shadow_count = '0;
        shadow_pos   = '0;
      end
      CMD_REMOVE: begin
        if (shadow_count != 0) shadow_count = shadow_count - 1'b1;
      end
      default: begin
        // an interval of zero acts as one; counter wrap also expires
        lim = (shadow_interval == 0) ? 24'd1 : shadow_interval;
        nxt = shadow_ticks + 1'b1;
        if (nxt < lim && nxt != 0) begin
          shadow_ticks = nxt;
        end else begin
          shadow_ticks = '0;
          step_player  = 1'b1;
          if (shadow_count != 0) begin
            // a remove may leave the position past the count: wrap to line 0
            if (shadow_pos >= shadow_count) shadow_pos = '0;
            shown      = shadow_store[shadow_pos];
            shadow_pos = shadow_pos + 1'b1;
            if (shadow_pos >= shadow_count) shadow_pos = '0;
          end
        end
      end
    endcase
  endfunction

  task automatic queue_line(input logic [LW-1:0] line);
    serial_bit_t sb;
    for (int k = 0; k < LW; k++) begin
      sb.data_bit  = line[k];
      sb.bit_index = k[BIT_INDEX_W-1:0];
      sb.latch     = (k == LW - 1);
      pending_bits = {pending_bits, sb};
    end
  endtask

  // Offer one request, hold it until taken, then book its expected bits.
  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic [IN_LINE_W-1:0] bits,
                              input exp_kind_t kind,
                              input logic [LW-1:0] typed);
    logic [LW-1:0] line;
    bit            fired;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_line_bits <= bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    req_taken++;
    fired = step_player(cmd, bits, line);
    case (kind)
      EXP_MODEL: if (fired) queue_line(line);
      EXP_LINE:  queue_line(typed);
      default:   ;
    endcase
  endtask

  // Drop valid, wait for every owed bit, then let the block go idle.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_interval(input logic [INTERVAL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_interval = val;
    cfg_writes++;
  endtask

  task automatic add_row(input logic set_cfg, input logic [INTERVAL_W-1:0] cfg_val,
                         input logic [CMD_W-1:0] cmd, input logic [IN_LINE_W-1:0] bits,
                         input int reps, input exp_kind_t kind,
                         input logic [LW-1:0] line);
    plan_row_t r;
    r.set_cfg = set_cfg;
    r.cfg_val = cfg_val;
    r.cmd     = cmd;
    r.bits    = bits;
    r.reps    = reps[15:0];
    r.kind    = kind;
    r.line    = line;
    plan = {plan, r};
  endtask

  function automatic logic [IN_LINE_W-1:0] rand_line();
    return IN_LINE_W'({$urandom, $urandom});
  endfunction

  // Random requests, mostly ticks and appends so short stores get played
  // and wrapped; rewrite the interval every dozen requests.
  task automatic run_random(input int n);
    int                    r;
    logic [CMD_W-1:0]      cmd;
    logic [INTERVAL_W-1:0] ival;
    for (int i = 0; i < n; i++) begin
      if (i % 12 == 0) begin
        settle_block();
        r = $urandom_range(0, 9);
        if (r == 0)      ival = '0;
        else if (r == 1) ival = '1;
        else if (r == 2) ival = INTERVAL_W'($urandom_range(20, 200));
        else             ival = INTERVAL_W'($urandom_range(1, 4));
        write_interval(ival);
      end
      r = $urandom_range(0, 99);
      if (r < 50)      cmd = CMD_TICK;
      else if (r < 80) cmd = CMD_APPEND;
      else if (r < 86) cmd = CMD_CLEAR;
      else             cmd = CMD_REMOVE;
      send_request(cmd, rand_line(), EXP_MODEL, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall, or a long hold-off when the sender asks for one
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Output check: compare each taken bit with the oldest owed bit
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    serial_bit_t want;
    if (rst_n && out_valid && !out_stall) begin
      bits_checked++;
      if (pending_bits.size() == 0) begin
        flag_error($sformatf("unexpected bit: data %0b index %0d latch %0b",
                             out_data_bit, out_bit_index, out_latch));
      end else begin
        want = pending_bits.pop_front();
        if (out_data_bit !== want.data_bit)
          flag_error($sformatf("data_bit %0b, want %0b at index %0d",
                               out_data_bit, want.data_bit, want.bit_index));
        if (out_bit_index !== want.bit_index)
          flag_error($sformatf("bit_index %0d, want %0d",
                               out_bit_index, want.bit_index));
        if (out_latch !== want.latch)
          flag_error($sformatf("latch %0b, want %0b at index %0d",
                               out_latch, want.latch, want.bit_index));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no handshake happens for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TIMEOUT: no handshake for %0d cycles, %0d bits owed",
               QUIET_LIMIT, pending_bits.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Directed plan. Typed lines are the ones readable at a glance.
    // the reset interval is long: a few ticks give nothing
    add_row(1'b0, 24'd0, CMD_TICK, '0, 3, EXP_QUIET, '0);
    // remove on an empty store is ignored; interval lowered below the count
    // fires on the next tick with a line of zeros
    add_row(1'b1, 24'd1, CMD_REMOVE, '0, 1, EXP_QUIET, '0);
    add_row(1'b0, 24'd0, CMD_TICK, '0, 1, EXP_LINE, '0);
    // two lines, played in order and wrapped
    add_row(1'b0, 24'd0, CMD_APPEND, 48'hFFFF_FFFF_FFFF, 1, EXP_QUIET, '0);
    add_row(1'b0, 24'd0, CMD_APPEND, 48'h8000_0000_0001, 1, EXP_QUIET, '0);
    add_row(1'b0, 24'd0, CMD_TICK, '0, 1, EXP_LINE, 48'hFFFF_FFFF_FFFF);
    add_row(1'b0, 24'd0, CMD_TICK, '0, 1, EXP_LINE, 48'h8000_0000_0001);
    add_row(1'b0, 24'd0, CMD_TICK, '0, 1, EXP_LINE, 48'hFFFF_FFFF_FFFF);
    // interval zero acts as one
    add_row(1'b1, 24'd0, CMD_TICK, '0, 2, EXP_MODEL, '0);
    // remove leaves the position past the count: wrap to line 0
    add_row(1'b0, 24'd0, CMD_REMOVE, '0, 1, EXP_QUIET, '0);
    add_row(1'b0, 24'd0, CMD_TICK, '0, 1, EXP_MODEL, '0);
    // clear empties the store and rewinds
    add_row(1'b0, 24'd0, CMD_APPEND, 48'hA5A5_5A5A_0F0F, 1, EXP_QUIET, '0);
    add_row(1'b0, 24'd0, CMD_CLEAR, '1, 1, EXP_QUIET, '0);
    add_row(1'b0, 24'd0, CMD_TICK, '0, 1, EXP_LINE, '0);
    // largest interval, then lowered below the count: next tick fires
    add_row(1'b1, 24'hFF_FFFF, CMD_TICK, '0, 5, EXP_QUIET, '0);
    add_row(1'b1, 24'd3, CMD_TICK, '0, 1, EXP_LINE, '0);
    // count a short interval out exactly
    add_row(1'b1, 24'd6, CMD_APPEND, 48'h1234_5678_9ABC, 1, EXP_QUIET, '0);
    add_row(1'b0, 24'd0, CMD_TICK, '0, 5, EXP_QUIET, '0);
    add_row(1'b0, 24'd0, CMD_TICK, '0, 1, EXP_LINE, 48'h1234_5678_9ABC);
    // non-tick commands do not count time
    add_row(1'b1, 24'd2, CMD_APPEND, 48'h5555_5555_5555, 1, EXP_QUIET, '0);
    add_row(1'b0, 24'd0, CMD_TICK, '0, 1, EXP_QUIET, '0);
    add_row(1'b0, 24'd0, CMD_APPEND, 48'h0000_0000_0000, 1, EXP_QUIET, '0);
    add_row(1'b0, 24'd0, CMD_REMOVE, '0, 1, EXP_QUIET, '0);
    add_row(1'b0, 24'd0, CMD_TICK, '0, 4, EXP_MODEL, '0);

    // hold reset, then release it for good
    snd_idle_pct = 21;
    rcv_idle_pct = 59;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].set_cfg) begin
        settle_block();
        write_interval(plan[i].cfg_val);
      end
      repeat (plan[i].reps) send_request(plan[i].cmd, plan[i].bits, plan[i].kind,
                                         plan[i].line);
    end

    // phase 1: sender idles lightly, receiver heavily
    run_random(RAND_ITEMS);

    // phase 2: the other way round
    snd_idle_pct = 59;
    rcv_idle_pct = 21;
    run_random(RAND_ITEMS);

    // phase 3: no idling; start with a long receiver hold-off while ticks
    // keep coming, so the block backs up and stalls its input
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    settle_block();
    write_interval(24'd1);
    send_request(CMD_APPEND, rand_line(), EXP_MODEL, '0);
    hold_req++;
    repeat (8) send_request(CMD_TICK, '0, EXP_MODEL, '0);
    run_random(RAND_ITEMS);

    // drain the tail and give the block time to show anything stray
    settle_block();
    if (pending_bits.size() != 0)
      flag_error($sformatf("%0d expected bits never arrived", pending_bits.size()));

    $display("Run covered %0d requests, %0d interval writes, %0d serial bits checked",
             req_taken, cfg_writes, bits_checked);
    $display("Directed extremes, three idling mixes and a receiver hold-off");
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
